@@ hw/rtl/tli_pkg.sv @@
package tli_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int WL_W       = 16;
	localparam int EFF_W      = 17;
	localparam int PROD_W     = WL_W + EFF_W;
	localparam int STEP_W     = $clog2(EFF_W + 1);

	localparam logic [EFF_W-1:0] ONE_Q16 = EFF_W'(65536);

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NOP    = 2'd3
	} tli_op_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_SPAN      = 3'd1,
		STAT_ABOVE_ONE = 3'd2,
		STAT_NOT_ASC   = 3'd3,
		STAT_FULL      = 3'd4
	} tli_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_CMP,
		S_LOWER,
		S_MUL,
		S_DIV,
		S_FIN
	} tli_state_t;

	typedef struct packed {
		tli_op_t          op;
		logic [WL_W-1:0]  wavelength;
		logic [EFF_W-1:0] efficiency;
	} tli_cmd_t;

	typedef struct packed {
		logic [EFF_W-1:0] result_efficiency;
		tli_status_t      status;
	} tli_result_t;

	typedef struct packed {
		logic [WL_W-1:0]  wl;
		logic [EFF_W-1:0] eff;
	} tli_point_t;

endpackage

@@ hw/rtl/tli_ram.sv @@
module tli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/table_linear_interpolator.sv @@
// Piecewise linear lookup over up to 64 ascending points held in one on-chip RAM.
// A transaction is taken when start is high and busy is low, and exactly one
// result follows: done is high for one cycle with the result, and the receiver
// cannot hold it off. Clear, append, the unused op code and an out-of-span or
// empty-table query answer in the cycle after acceptance, and busy stays low, so
// such transactions can follow each other every cycle. An in-span query holds busy
// while it runs a binary search through the point RAM (one RAM read per probe),
// reads the lower neighbor, multiplies, and then runs a 17-step restoring divider;
// a query that hits the first point ends after the search.
module table_linear_interpolator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  tli_pkg::tli_cmd_t    cmd,
	output logic                 done,
	output tli_pkg::tli_result_t result
);

	tli_pkg::tli_state_t state_q, state_d;

	logic [tli_pkg::CNT_W-1:0]  count_q;
	logic [tli_pkg::WL_W-1:0]   first_wl_q, last_wl_q, w_q;
	logic [tli_pkg::CNT_W-1:0]  lo_q, hi_q, mid_q;
	logic [tli_pkg::WL_W-1:0]   uw_q, lw_q, den_q;
	logic [tli_pkg::EFF_W-1:0]  ue_q, le_q, quo_q, nlow_q;
	logic [tli_pkg::WL_W-1:0]   rem_q;
	logic                       neg_q;
	logic [tli_pkg::STEP_W-1:0] step_q;
	tli_pkg::tli_result_t       result_q;
	logic                       done_q;

	logic                       accept;
	logic                       out_of_span;
	tli_pkg::tli_status_t       append_status;
	logic                       ram_we;
	logic [tli_pkg::IDX_W-1:0]  ram_raddr;
	tli_pkg::tli_point_t        ram_wdata, ram_rdata;
	logic [tli_pkg::CNT_W-1:0]  mid_c, lo_m1;
	logic [tli_pkg::WL_W-1:0]   diff_w;
	logic [tli_pkg::EFF_W-1:0]  diff_e_mag;
	logic [tli_pkg::PROD_W-1:0] prod;
	logic [tli_pkg::WL_W:0]     trial;
	logic                       trial_ge;

	assign busy   = (state_q != tli_pkg::S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	assign out_of_span = (count_q == '0) || (cmd.wavelength < first_wl_q) ||
		(cmd.wavelength > last_wl_q);

	always_comb begin
		if (cmd.efficiency > tli_pkg::ONE_Q16) begin
			append_status = tli_pkg::STAT_ABOVE_ONE;
		end else if (count_q != '0 && cmd.wavelength <= last_wl_q) begin
			append_status = tli_pkg::STAT_NOT_ASC;
		end else if (count_q >= tli_pkg::CNT_W'(tli_pkg::MAX_POINTS)) begin
			append_status = tli_pkg::STAT_FULL;
		end else begin
			append_status = tli_pkg::STAT_OK;
		end
	end

	assign mid_c = lo_q + ((hi_q - lo_q) >> 1);
	assign lo_m1 = lo_q - tli_pkg::CNT_W'(1);

	assign ram_we        = accept && cmd.op == tli_pkg::OP_APPEND &&
		append_status == tli_pkg::STAT_OK;
	assign ram_wdata.wl  = cmd.wavelength;
	assign ram_wdata.eff = cmd.efficiency;

	tli_ram #(
		.WIDTH($bits(tli_pkg::tli_point_t)),
		.DEPTH(tli_pkg::MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[tli_pkg::IDX_W-1:0]),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state and read address
	always_comb begin
		state_d   = state_q;
		ram_raddr = '0;
		case (state_q)
			tli_pkg::S_IDLE: begin
				if (accept && cmd.op == tli_pkg::OP_QUERY && !out_of_span) begin
					state_d = tli_pkg::S_SEARCH;
				end
			end
			tli_pkg::S_SEARCH: begin
				if (lo_q < hi_q) begin
					ram_raddr = mid_c[tli_pkg::IDX_W-1:0];
					state_d   = tli_pkg::S_CMP;
				end else if (lo_q == '0) begin
					state_d = tli_pkg::S_IDLE;
				end else begin
					ram_raddr = lo_m1[tli_pkg::IDX_W-1:0];
					state_d   = tli_pkg::S_LOWER;
				end
			end
			tli_pkg::S_CMP:   state_d = tli_pkg::S_SEARCH;
			tli_pkg::S_LOWER: state_d = tli_pkg::S_MUL;
			tli_pkg::S_MUL:   state_d = tli_pkg::S_DIV;
			tli_pkg::S_DIV: begin
				if (step_q == tli_pkg::STEP_W'(1)) begin
					state_d = tli_pkg::S_FIN;
				end
			end
			tli_pkg::S_FIN:   state_d = tli_pkg::S_IDLE;
			default:          state_d = tli_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tli_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table bookkeeping and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept && cmd.op != tli_pkg::OP_QUERY) begin
				done_q <= 1'b1;
				if (cmd.op == tli_pkg::OP_CLEAR) begin
					count_q <= '0;
				end else if (ram_we) begin
					count_q <= count_q + tli_pkg::CNT_W'(1);
				end
			end else if (accept && out_of_span) begin
				done_q <= 1'b1;
			end else if (state_q == tli_pkg::S_SEARCH && lo_q >= hi_q && lo_q == '0) begin
				done_q <= 1'b1;
			end else if (state_q == tli_pkg::S_FIN) begin
				done_q <= 1'b1;
			end
		end
	end

	// magnitude of the efficiency step, sign kept apart so the divider truncates toward zero
	assign diff_w     = w_q - lw_q;
	assign diff_e_mag = (ue_q >= le_q) ? (ue_q - le_q) : (le_q - ue_q);
	assign prod       = diff_w * diff_e_mag;

	assign trial    = {rem_q, nlow_q[tli_pkg::EFF_W-1]};
	assign trial_ge = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (ram_we) begin
			last_wl_q <= cmd.wavelength;
			if (count_q == '0) begin
				first_wl_q <= cmd.wavelength;
			end
		end
		if (accept) begin
			result_q.result_efficiency <= '0;
			w_q   <= cmd.wavelength;
			lo_q  <= '0;
			hi_q  <= count_q;
			case (cmd.op)
				tli_pkg::OP_APPEND: result_q.status <= append_status;
				tli_pkg::OP_QUERY:  result_q.status <= out_of_span ? tli_pkg::STAT_SPAN :
					tli_pkg::STAT_OK;
				default:            result_q.status <= tli_pkg::STAT_OK;
			endcase
		end
		case (state_q)
			tli_pkg::S_SEARCH: begin
				mid_q <= mid_c;
				if (lo_q >= hi_q && lo_q == '0) begin
					result_q.result_efficiency <= ue_q;
					result_q.status            <= tli_pkg::STAT_OK;
				end
			end
			tli_pkg::S_CMP: begin
				if (ram_rdata.wl < w_q) begin
					lo_q <= mid_q + tli_pkg::CNT_W'(1);
				end else begin
					hi_q <= mid_q;
					uw_q <= ram_rdata.wl;
					ue_q <= ram_rdata.eff;
				end
			end
			tli_pkg::S_LOWER: begin
				lw_q <= ram_rdata.wl;
				le_q <= ram_rdata.eff;
			end
			tli_pkg::S_MUL: begin
				// quotient fits 17 bits, so the upper product bits start below the divisor
				rem_q  <= prod[tli_pkg::PROD_W-1:tli_pkg::EFF_W];
				nlow_q <= prod[tli_pkg::EFF_W-1:0];
				neg_q  <= (ue_q < le_q);
				den_q  <= uw_q - lw_q;
				quo_q  <= '0;
				step_q <= tli_pkg::STEP_W'(tli_pkg::EFF_W);
			end
			tli_pkg::S_DIV: begin
				rem_q  <= trial_ge ? tli_pkg::WL_W'(trial - {1'b0, den_q}) :
					trial[tli_pkg::WL_W-1:0];
				nlow_q <= {nlow_q[tli_pkg::EFF_W-2:0], 1'b0};
				quo_q  <= {quo_q[tli_pkg::EFF_W-2:0], trial_ge};
				step_q <= step_q - tli_pkg::STEP_W'(1);
			end
			tli_pkg::S_FIN: begin
				result_q.result_efficiency <= neg_q ? (le_q - quo_q) : (le_q + quo_q);
				result_q.status            <= tli_pkg::STAT_OK;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/tli_check.sv @@
module tli_check (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input tli_pkg::tli_cmd_t    cmd,
	input logic                 done,
	input tli_pkg::tli_result_t result
);

	// table edits and unused codes answer right away
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.op != tli_pkg::OP_QUERY |=> done && !busy)
		else $error("non-query transaction not answered in the next cycle");

	// a query either answers at once or holds busy
	a_query_follow: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.op == tli_pkg::OP_QUERY |=> done || busy)
		else $error("query neither answered nor in progress");

	a_no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe while a query is in progress");

	a_error_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != tli_pkg::STAT_OK |-> result.result_efficiency == '0)
		else $error("nonzero efficiency with an error status");

	a_value_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.result_efficiency <= tli_pkg::ONE_Q16 &&
			result.status <= tli_pkg::STAT_FULL)
		else $error("result out of range");

endmodule

bind table_linear_interpolator tli_check u_tli_check (.*);
